// ===== sv/amg_pkg.sv =====
package amg_pkg;

    localparam int MaxOrder = 4;
    localparam int MaxElems = 64;

    localparam int SampleW  = 16;
    localparam int FracW    = 14;
    localparam int ProdW    = 2 * SampleW;
    localparam int AccW     = ProdW + 3;
    localparam int ElemW    = $clog2(MaxElems);
    localparam int ElemsW   = $clog2(MaxElems + 1);
    localparam int SlotW    = $clog2(MaxOrder);
    localparam int OrderW   = $clog2(MaxOrder + 1);
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam int RoundBias = 1 << (FracW - 1);
    localparam int SatMax    = (1 << (SampleW - 1)) - 1;
    localparam int SatMin    = -(1 << (SampleW - 1));

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ORDER = 3'd0,
        CFG_ELEMS = 3'd1,
        CFG_COEF0 = 3'd2,
        CFG_COEF1 = 3'd3,
        CFG_COEF2 = 3'd4,
        CFG_COEF3 = 3'd5
    } cfg_idx_t;

    typedef logic [ElemW-1:0]                 elem_t;
    typedef logic [SlotW-1:0]                 slot_t;
    typedef logic [OrderW-1:0]                order_t;
    typedef logic [MaxOrder-1:0][SampleW-1:0] row_t;
    typedef logic [MaxOrder-1:0][SampleW-1:0] coef_vec_t;
    typedef logic [MaxOrder-1:0][ProdW-1:0]   prod_vec_t;

    typedef struct packed {
        elem_t                    elem;
        slot_t                    slot;
        slot_t [MaxOrder-1:0]     src;
        logic  [MaxOrder-1:0]     tap_en;
        logic                     last;
    } issue_t;

    function automatic order_t eff_order(input order_t o);
        order_t r;
        if (o == '0) begin
            r = OrderW'(1);
        end else if (o > OrderW'(MaxOrder)) begin
            r = OrderW'(MaxOrder);
        end else begin
            r = o;
        end
        return r;
    endfunction

    function automatic logic [ElemsW-1:0] eff_elems(input logic [ElemsW-1:0] n);
        logic [ElemsW-1:0] r;
        if (n == '0) begin
            r = ElemsW'(1);
        end else if (n > ElemsW'(MaxElems)) begin
            r = ElemsW'(MaxElems);
        end else begin
            r = n;
        end
        return r;
    endfunction

    function automatic slot_t slot_mod(input slot_t p, input order_t o);
        slot_t r;
        if (o == OrderW'(1)) begin
            r = '0;
        end else if (OrderW'(p) >= o) begin
            r = SlotW'(OrderW'(p) - o);
        end else begin
            r = p;
        end
        return r;
    endfunction

    function automatic slot_t slot_inc(input slot_t s, input order_t o);
        logic [OrderW-1:0] t;
        t = OrderW'(s) + OrderW'(1);
        return (t >= o) ? '0 : SlotW'(t);
    endfunction

    function automatic slot_t tap_src(input slot_t s, input order_t o, input slot_t j);
        logic [OrderW:0] t;
        t = (OrderW+1)'(s) + (OrderW+1)'(o) - (OrderW+1)'(1) - (OrderW+1)'(j);
        if (t >= (OrderW+1)'(o)) begin
            t = t - (OrderW+1)'(o);
        end
        return SlotW'(t);
    endfunction

endpackage

// ===== sv/amg_hist_mem.sv =====
module amg_hist_mem import amg_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  rd_en,
    input  elem_t rd_addr,
    output row_t  rd_row,
    output logic  rd_hit,
    input  logic  wr_en,
    input  elem_t wr_addr,
    input  row_t  wr_row
);

    row_t                hist_mem [MaxElems];
    row_t                rd_row_reg;
    logic                rd_hit_reg;
    logic [MaxElems-1:0] row_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_row_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_hit = rd_hit_reg;

endmodule

// ===== sv/amg_seq.sv =====
module amg_seq import amg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                accept,
    output issue_t              issue,
    output coef_vec_t           coef
);

    order_t            order_reg;
    logic [ElemsW-1:0] elems_reg;
    coef_vec_t         coef_reg;
    elem_t             cnt_reg;
    elem_t             cnt_next;
    slot_t             ptr_reg;
    slot_t             ptr_next;
    order_t            order_eff;
    logic [ElemsW-1:0] elems_eff;
    slot_t             slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= OrderW'(1);
            elems_reg <= ElemsW'(MaxElems);
            coef_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORDER: order_reg   <= cfg_data[OrderW-1:0];
                CFG_ELEMS: elems_reg   <= cfg_data[ElemsW-1:0];
                CFG_COEF0: coef_reg[0] <= cfg_data;
                CFG_COEF1: coef_reg[1] <= cfg_data;
                CFG_COEF2: coef_reg[2] <= cfg_data;
                CFG_COEF3: coef_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        order_eff   = eff_order(order_reg);
        elems_eff   = eff_elems(elems_reg);
        slot        = slot_mod(ptr_reg, order_eff);
        issue.elem  = cnt_reg;
        issue.slot  = slot;
        issue.last  = (ElemsW'(cnt_reg) + ElemsW'(1)) >= elems_eff;
        for (int j = 0; j < MaxOrder; j++) begin
            issue.src[j]    = tap_src(slot, order_eff, SlotW'(j));
            issue.tap_en[j] = OrderW'(j) < order_eff;
        end
        if (issue.last) begin
            cnt_next = '0;
            ptr_next = slot_inc(slot, order_eff);
        end else begin
            cnt_next = cnt_reg + ElemW'(1);
            ptr_next = slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ===== sv/autoregressive_matrix_generator_core.sv =====
// Element-wise AR process generator. Each input beat carries the noise sample
// for the next element of the matrix being built; each output beat returns the
// new Q2.14 value (rounded, saturated), its element index and an end-of-matrix
// flag. The history of order_in_use matrices sits in one synchronous memory
// with one row per element (all slots side by side), read when a beat is taken
// and written back from s2 as its result moves to the output register. One
// beat is taken per cycle unless a full pipeline or the row interlock stalls
// s_ready. With elements_in_use at 1 every beat hits the same row; the interlock
// stalls a new one while the last is in s1, or in s2 with the output stalled.
// The history reads as zero after reset through per-row valid bits, so no
// clearing pass is needed. Write the configuration only while no beat is in flight.
module autoregressive_matrix_generator_core import amg_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CfgIdxW-1:0]         cfg_index,
    input  logic [CfgDataW-1:0]        cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SampleW-1:0]  s_noise_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SampleW-1:0]  m_sample_value,
    output logic [ElemW-1:0]           m_element_index,
    output logic                       m_matrix_last
);

    issue_t    issue;
    coef_vec_t coef;
    logic      accept;
    row_t      rd_row;
    logic      rd_hit;
    logic      wr_en;
    row_t      wr_row;

    logic      out_adv;
    logic      s2_en;
    logic      s1_en;
    logic      hazard;

    logic                      s1_vld_reg;
    issue_t                    s1_info_reg;
    logic signed [SampleW-1:0] s1_noise_reg;
    row_t                      row_eff;
    prod_vec_t                 prod;

    logic                      s2_vld_reg;
    prod_vec_t                 s2_prod_reg;
    logic signed [SampleW-1:0] s2_noise_reg;
    row_t                      s2_row_reg;
    elem_t                     s2_elem_reg;
    slot_t                     s2_slot_reg;
    logic                      s2_last_reg;
    logic signed [AccW-1:0]    acc;
    logic signed [AccW-1:0]    q;
    logic signed [SampleW-1:0] sat;

    logic                      wb_vld_reg;
    elem_t                     wb_elem_reg;
    row_t                      wb_row_reg;

    logic                      m_valid_reg;
    logic signed [SampleW-1:0] m_sample_value_reg;
    elem_t                     m_element_index_reg;
    logic                      m_matrix_last_reg;

    amg_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .issue     (issue),
        .coef      (coef)
    );

    amg_hist_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (issue.elem),
        .rd_row  (rd_row),
        .rd_hit  (rd_hit),
        .wr_en   (wr_en),
        .wr_addr (s2_elem_reg),
        .wr_row  (wr_row)
    );

    assign out_adv = !m_valid_reg || m_ready;
    assign s2_en   = !s2_vld_reg || out_adv;
    assign s1_en   = !s1_vld_reg || s2_en;
    assign hazard  = (s1_vld_reg && (issue.elem == s1_info_reg.elem)) ||
                     (s2_vld_reg && !out_adv && (issue.elem == s2_elem_reg));
    assign s_ready = s1_en && !hazard;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s1_en) begin
            s1_vld_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg  <= issue;
            s1_noise_reg <= s_noise_sample;
        end
    end

    // forward the latest write-back; it covers the write that races the read
    always_comb begin
        logic signed [SampleW-1:0] c_s;
        logic signed [SampleW-1:0] h_s;
        if (wb_vld_reg && (wb_elem_reg == s1_info_reg.elem)) begin
            row_eff = wb_row_reg;
        end else if (rd_hit) begin
            row_eff = rd_row;
        end else begin
            row_eff = '0;
        end
        for (int j = 0; j < MaxOrder; j++) begin
            c_s = $signed(coef[j]);
            h_s = $signed(row_eff[s1_info_reg.src[j]]);
            if (s1_info_reg.tap_en[j]) begin
                prod[j] = c_s * h_s;
            end else begin
                prod[j] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (s2_en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_vld_reg && s2_en) begin
            s2_prod_reg  <= prod;
            s2_noise_reg <= s1_noise_reg;
            s2_row_reg   <= row_eff;
            s2_elem_reg  <= s1_info_reg.elem;
            s2_slot_reg  <= s1_info_reg.slot;
            s2_last_reg  <= s1_info_reg.last;
        end
    end

    always_comb begin
        acc = (AccW'(s2_noise_reg) <<< FracW) + AccW'(RoundBias);
        for (int j = 0; j < MaxOrder; j++) begin
            acc = acc + AccW'($signed(s2_prod_reg[j]));
        end
        q = acc >>> FracW;
        if (q > AccW'(SatMax)) begin
            sat = SampleW'(SatMax);
        end else if (q < AccW'(SatMin)) begin
            sat = SampleW'(SatMin);
        end else begin
            sat = q[SampleW-1:0];
        end
        wr_row              = s2_row_reg;
        wr_row[s2_slot_reg] = sat;
    end

    assign wr_en = s2_vld_reg && out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_vld_reg <= 1'b0;
        end else if (wr_en) begin
            wb_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wb_elem_reg         <= s2_elem_reg;
            wb_row_reg          <= wr_row;
            m_sample_value_reg  <= sat;
            m_element_index_reg <= s2_elem_reg;
            m_matrix_last_reg   <= s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s2_vld_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample_value  = m_sample_value_reg;
    assign m_element_index = m_element_index_reg;
    assign m_matrix_last   = m_matrix_last_reg;

endmodule

// ===== verif/autoregressive_matrix_generator_core_test.sv =====
module autoregressive_matrix_generator_core_test;
    import amg_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE7 = 3'd7;
    localparam cfg_idx_t CoefReg [MaxOrder] = '{CFG_COEF0, CFG_COEF1, CFG_COEF2, CFG_COEF3};
    localparam int DirectedRows = 30;
    localparam int RandomPhases = 16;
    localparam int MaxReported = 10;

    typedef enum bit {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct packed {
        logic signed [SampleW-1:0] value;
        elem_t                     index;
        logic                      last;
    } sample_beat_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CfgIdxW-1:0]     idx;
        logic [CfgDataW-1:0]    data;
        bit                     typed;
        sample_beat_t           beat;
    } dir_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]        cfg_index = '0;
    logic [CfgDataW-1:0]       cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [SampleW-1:0] s_noise_sample = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [SampleW-1:0] m_sample_value;
    elem_t                     m_element_index;
    logic                      m_matrix_last;

    // process state and register mirror
    logic signed [SampleW-1:0] history [MaxOrder][MaxElems];
    int unsigned               elem_cnt;
    int unsigned               slot_ptr;
    order_t                    order_reg;
    logic [ElemsW-1:0]         elems_reg;
    logic signed [SampleW-1:0] tap_coef [MaxOrder];

    sample_beat_t expected_samples [$];
    dir_row_t     directed_rows [DirectedRows];
    int unsigned  send_idle_pct = 0;
    int unsigned  sink_stall_pct = 0;
    int           beats_accepted = 0;
    int           results_taken = 0;
    int           mismatches = 0;

    autoregressive_matrix_generator_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_noise_sample  (s_noise_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value),
        .m_element_index (m_element_index),
        .m_matrix_last   (m_matrix_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dir_row_t beat_row(input logic [SampleW-1:0] noise);
        dir_row_t r;
        r = '0;
        r.kind = ROW_BEAT;
        r.data = noise;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic [SampleW-1:0] noise,
                                           input logic [SampleW-1:0] value,
                                           input elem_t index, input logic last);
        dir_row_t r;
        r = beat_row(noise);
        r.typed = 1'b1;
        r.beat.value = value;
        r.beat.index = index;
        r.beat.last = last;
        return r;
    endfunction

    function automatic void reset_ar_state();
        for (int s = 0; s < MaxOrder; s++) begin
            for (int e = 0; e < MaxElems; e++) begin
                history[s][e] = '0;
            end
            tap_coef[s] = '0;
        end
        elem_cnt = 0;
        slot_ptr = 0;
        order_reg = OrderW'(1);
        elems_reg = ElemsW'(MaxElems);
    endfunction

    function automatic void apply_reg_write(input logic [CfgIdxW-1:0] idx,
                                            input logic [CfgDataW-1:0] data);
        case (idx)
            CFG_ORDER: order_reg = data[OrderW-1:0];
            CFG_ELEMS: elems_reg = data[ElemsW-1:0];
            CFG_COEF0: tap_coef[0] = data[SampleW-1:0];
            CFG_COEF1: tap_coef[1] = data[SampleW-1:0];
            CFG_COEF2: tap_coef[2] = data[SampleW-1:0];
            CFG_COEF3: tap_coef[3] = data[SampleW-1:0];
            default: ;
        endcase
    endfunction

    function automatic sample_beat_t ar_step(input logic signed [SampleW-1:0] noise);
        sample_beat_t b;
        int unsigned  ord;
        int unsigned  nel;
        int unsigned  slot;
        int unsigned  elem;
        int unsigned  src;
        longint       acc;
        longint       q;
        ord = (order_reg == 0) ? 1 : (order_reg > MaxOrder) ? MaxOrder : order_reg;
        nel = (elems_reg == 0) ? 1 : (elems_reg > MaxElems) ? MaxElems : elems_reg;
        slot = slot_ptr % ord;
        elem = (elem_cnt > MaxElems - 1) ? MaxElems - 1 : elem_cnt;
        acc = longint'(noise) * (longint'(1) << FracW);
        for (int j = 0; j < ord; j++) begin
            src = (slot + ord - 1 - j) % ord;
            acc += longint'(tap_coef[j]) * longint'(history[src][elem]);
        end
        q = (acc + RoundBias) >>> FracW;
        if (q > SatMax) begin
            q = SatMax;
        end
        if (q < SatMin) begin
            q = SatMin;
        end
        history[slot][elem] = q[SampleW-1:0];
        b.value = q[SampleW-1:0];
        b.index = elem_cnt[ElemW-1:0];
        b.last = (elem_cnt + 1 >= nel);
        if (b.last) begin
            elem_cnt = 0;
            slot_ptr = (slot + 1) % ord;
        end else begin
            elem_cnt = elem_cnt + 1;
            slot_ptr = slot;
        end
        return b;
    endfunction

    function automatic logic [SampleW-1:0] random_noise();
        int n;
        if ($urandom_range(2) == 0) begin
            n = int'($urandom);
        end else begin
            n = int'($urandom_range(8192)) - 4096;
        end
        return n[SampleW-1:0];
    endfunction

    task automatic push_noise(input logic [SampleW-1:0] noise, input bit typed,
                              input sample_beat_t typed_beat);
        sample_beat_t b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_noise_sample <= SampleW'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_noise_sample <= noise;
        do @(posedge aclk); while (!s_ready);
        beats_accepted++;
        b = ar_step(noise);
        expected_samples.push_back(typed ? typed_beat : b);
    endtask

    // drop valid and hold until every accepted beat has come back
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (results_taken < beats_accepted) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        apply_reg_write(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic randomize_setup();
        logic [CfgDataW-1:0] d;
        int                  r;
        int                  c;
        d = CfgDataW'($urandom);
        d[OrderW-1:0] = ($urandom_range(9) < 7) ? OrderW'($urandom_range(1, MaxOrder))
                                                 : OrderW'($urandom_range(0, 7));
        write_reg(CFG_ORDER, d);
        d = CfgDataW'($urandom);
        r = $urandom_range(9);
        if (r < 6) begin
            d[ElemsW-1:0] = ElemsW'($urandom_range(1, 8));
        end else if (r < 8) begin
            d[ElemsW-1:0] = ElemsW'($urandom_range(9, MaxElems));
        end else begin
            d[ElemsW-1:0] = ElemsW'($urandom_range(0, 127));
        end
        write_reg(CFG_ELEMS, d);
        for (int t = 0; t < MaxOrder; t++) begin
            r = $urandom_range(9);
            if (r == 0) begin
                d = 16'h7FFF;
            end else if (r == 1) begin
                d = 16'h8000;
            end else begin
                c = int'($urandom_range(16384)) - 8192;
                d = c[CfgDataW-1:0];
            end
            write_reg(CoefReg[t], d);
        end
        if ($urandom_range(3) == 0) begin
            write_reg($urandom_range(1) ? CFG_SPARE6 : CFG_SPARE7, CfgDataW'($urandom));
        end
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 62; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 62; end
            default: begin send_idle_pct = 27; sink_stall_pct = 27; end
        endcase
    endtask

    always @(posedge aclk) begin
        sample_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReported) begin
                    $display("%0t: unexpected beat value %0d index %0d last %0b", $time,
                             m_sample_value, m_element_index, m_matrix_last);
                end
            end else begin
                want = expected_samples.pop_front();
                if (m_sample_value !== want.value || m_element_index !== want.index
                        || m_matrix_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MaxReported) begin
                        $display("%0t: expected value %0d index %0d last %0b, got %0d %0d %0b",
                                 $time, $signed(want.value), want.index, want.last,
                                 m_sample_value, m_element_index, m_matrix_last);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        dir_row_t row;
        int       items;
        reset_ar_state();
        directed_rows = '{
            known_row(16'h7FFF, 16'h7FFF, 6'd0, 1'b0),
            known_row(16'h8000, 16'h8000, 6'd1, 1'b0),
            known_row(16'h0000, 16'h0000, 6'd2, 1'b0),
            known_row(16'hFFFF, 16'hFFFF, 6'd3, 1'b0),
            known_row(16'h0001, 16'h0001, 6'd4, 1'b0),
            cfg_row(CFG_ELEMS, 16'd3),
            known_row(16'h1234, 16'h1234, 6'd5, 1'b1),
            cfg_row(CFG_COEF0, 16'h7FFF),
            known_row(16'h7FFF, 16'h7FFF, 6'd0, 1'b0),
            known_row(16'h8000, 16'h8000, 6'd1, 1'b0),
            known_row(16'h0064, 16'h0064, 6'd2, 1'b1),
            cfg_row(CFG_SPARE6, 16'hFFFF),
            cfg_row(CFG_SPARE7, 16'h0001),
            known_row(16'h0000, 16'h7FFF, 6'd0, 1'b0),
            cfg_row(CFG_ORDER, 16'd7),
            cfg_row(CFG_COEF0, 16'h8000),
            cfg_row(CFG_COEF1, 16'h7FFF),
            cfg_row(CFG_COEF2, 16'h8000),
            cfg_row(CFG_COEF3, 16'h7FFF),
            cfg_row(CFG_ELEMS, 16'd0),
            beat_row(16'h2000),
            beat_row(16'hE000),
            beat_row(16'h0FFF),
            cfg_row(CFG_ORDER, 16'd2),
            cfg_row(CFG_ELEMS, 16'h007F),
            beat_row(16'h4000),
            beat_row(16'hC000),
            cfg_row(CFG_ORDER, 16'd0),
            beat_row(16'h0100),
            beat_row(16'h8000)
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_idling(3);
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                wait_for_idle();
                write_reg(row.idx, row.data);
            end else begin
                push_noise(row.data, row.typed, row.beat);
            end
        end
        for (int p = 0; p < RandomPhases; p++) begin
            wait_for_idle();
            set_idling(p % 4);
            randomize_setup();
            items = $urandom_range(15, 40);
            repeat (items) push_noise(random_noise(), 1'b0, '0);
        end
        wait_for_idle();
        repeat (8) @(posedge aclk);
        if (expected_samples.size() != 0) begin
            mismatches += expected_samples.size();
            $display("%0d expected beats never arrived", expected_samples.size());
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== autoregressive_matrix_generator_core.f =====
sv/amg_pkg.sv
sv/amg_hist_mem.sv
sv/amg_seq.sv
sv/autoregressive_matrix_generator_core.sv
verif/autoregressive_matrix_generator_core_test.sv
